// ===== rtl/bsp_pkg.sv =====
// Shared types, constants and helpers for the BMP stream parser.
package bsp_pkg;

  localparam int COORD_BITS = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [5:0] POS_MAGIC   = 6'd1;
  localparam logic [5:0] POS_WIDTH   = 6'd21;
  localparam logic [5:0] POS_HEIGHT  = 6'd25;
  localparam logic [5:0] POS_PLANES  = 6'd27;
  localparam logic [5:0] POS_DEPTH   = 6'd29;
  localparam logic [5:0] POS_COMPR   = 6'd33;
  localparam logic [5:0] POS_PALETTE = 6'd49;
  localparam logic [5:0] HEADER_LAST = 6'd53;

  localparam logic [15:0] MAGIC_BM  = 16'h4D42;
  localparam logic [15:0] PLANES_OK = 16'd1;
  localparam logic [15:0] DEPTH_OK  = 16'd24;

  localparam logic [2:0] ERR_MAGIC   = 3'd0;
  localparam logic [2:0] ERR_NEG     = 3'd1;
  localparam logic [2:0] ERR_PLANES  = 3'd2;
  localparam logic [2:0] ERR_DEPTH   = 3'd3;
  localparam logic [2:0] ERR_COMPR   = 3'd4;
  localparam logic [2:0] ERR_PALETTE = 3'd5;
  localparam logic [2:0] ERR_TRUNC   = 3'd6;
  localparam logic [2:0] ERR_SIZE    = 3'd7;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DROP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;
  } out_item_t;

  // One classified byte: an optional main result and an optional truncation error.
  typedef struct packed {
    logic      has_main;
    out_item_t res;
    logic      trunc;
  } cmd_t;

  // Lowest fault among codes 0..5 wins, else the size fault.
  function automatic logic [2:0] fault_code(input logic [6:0] flags);
    logic [2:0] code;
    code = ERR_SIZE;
    for (int i = 5; i >= 0; i--) begin
      if (flags[i]) code = 3'(i);
    end
    return code;
  endfunction

endpackage

// ===== rtl/bsp_front.sv =====
// Front end: accepts file bytes, parses header and pixel layout, emits commands.
module bsp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsp_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output bsp_pkg::cmd_t     push_cmd
);

  localparam int CW = bsp_pkg::COORD_BITS;

  bsp_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [31:0]   fa_r, fa_nxt;
  logic [6:0]    flags_r, flags_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] height_r, height_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] col_inc;
  logic [1:0]    ch_r, ch_nxt;
  logic [15:0]   bg_r, bg_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [15:0]   hi16;
  logic          accept;
  logic [7:0]    bval;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign bval     = in_data.byte_value;
  assign col_inc  = col_r + CW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fa_nxt     = fa_r;
    flags_nxt  = flags_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    bg_nxt     = bg_r;
    pad_nxt    = pad_r;
    hi16       = fa_r[31:16];
    push_cmd   = '0;
    push_cmd.res.kind = bsp_pkg::KIND_PIXEL;

    if (accept) begin
      case (phase_r)
        bsp_pkg::PH_HEADER: begin
          fa_nxt = {bval, fa_r[31:8]};
          hi16   = fa_nxt[31:16];
          if (pos_r == bsp_pkg::POS_MAGIC && hi16 != bsp_pkg::MAGIC_BM) begin
            flags_nxt[0] = 1'b1;
          end else if (pos_r == bsp_pkg::POS_WIDTH || pos_r == bsp_pkg::POS_HEIGHT) begin
            if (fa_nxt[31]) flags_nxt[1] = 1'b1;
            else if ((fa_nxt[30:0] >> CW) != 31'd0) flags_nxt[6] = 1'b1;
            if (pos_r == bsp_pkg::POS_WIDTH) width_nxt = fa_nxt[CW-1:0];
            else height_nxt = fa_nxt[CW-1:0];
          end else if (pos_r == bsp_pkg::POS_PLANES && hi16 != bsp_pkg::PLANES_OK) begin
            flags_nxt[2] = 1'b1;
          end else if (pos_r == bsp_pkg::POS_DEPTH && hi16 != bsp_pkg::DEPTH_OK) begin
            flags_nxt[3] = 1'b1;
          end else if (pos_r == bsp_pkg::POS_COMPR && fa_nxt != 32'd0) begin
            flags_nxt[4] = 1'b1;
          end else if (pos_r == bsp_pkg::POS_PALETTE && fa_nxt != 32'd0) begin
            flags_nxt[5] = 1'b1;
          end

          if (pos_r >= bsp_pkg::HEADER_LAST) begin
            push_cmd.has_main = 1'b1;
            if (flags_nxt != 7'd0) begin
              push_cmd.res.kind       = bsp_pkg::KIND_ERROR;
              push_cmd.res.error_code = bsp_pkg::fault_code(flags_nxt);
              phase_nxt = bsp_pkg::PH_DROP;
            end else begin
              push_cmd.res.kind         = bsp_pkg::KIND_HEADER;
              push_cmd.res.image_width  = 16'(width_nxt);
              push_cmd.res.image_height = 16'(height_nxt);
              col_nxt = '0;
              ch_nxt  = 2'd0;
              pad_nxt = 2'd0;
              if (width_nxt == '0 || height_nxt == '0) begin
                phase_nxt = bsp_pkg::PH_DROP;
              end else begin
                row_nxt   = height_nxt - CW'(1);
                phase_nxt = bsp_pkg::PH_PIXEL;
              end
            end
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        bsp_pkg::PH_PIXEL: begin
          if (ch_r == 2'd0) begin
            bg_nxt = {8'd0, bval};
            ch_nxt = 2'd1;
          end else if (ch_r == 2'd1) begin
            bg_nxt = {bval, bg_r[7:0]};
            ch_nxt = 2'd2;
          end else begin
            push_cmd.has_main   = 1'b1;
            push_cmd.res.kind   = bsp_pkg::KIND_PIXEL;
            push_cmd.res.row    = 16'(row_r);
            push_cmd.res.column = 16'(col_r);
            push_cmd.res.red    = bval;
            push_cmd.res.green  = bg_r[15:8];
            push_cmd.res.blue   = bg_r[7:0];
            ch_nxt = 2'd0;
            if (col_inc >= width_r) begin
              col_nxt = '0;
              if (row_r == '0) begin
                phase_nxt = bsp_pkg::PH_DROP;
              end else begin
                row_nxt = row_r - CW'(1);
                pad_nxt = width_r[1:0];
                if (width_r[1:0] != 2'd0) phase_nxt = bsp_pkg::PH_PAD;
              end
            end else begin
              col_nxt = col_inc;
            end
          end
        end
        bsp_pkg::PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) phase_nxt = bsp_pkg::PH_PIXEL;
        end
        bsp_pkg::PH_DROP: begin
        end
        default: begin
          phase_nxt = bsp_pkg::PH_DROP;
        end
      endcase

      // End of file: flag truncation unless done, then start over for the next file.
      if (in_data.end_of_file) begin
        push_cmd.trunc = (phase_nxt != bsp_pkg::PH_DROP);
        phase_nxt  = bsp_pkg::PH_HEADER;
        pos_nxt    = '0;
        fa_nxt     = '0;
        flags_nxt  = '0;
        width_nxt  = '0;
        height_nxt = '0;
        row_nxt    = '0;
        col_nxt    = '0;
        ch_nxt     = '0;
        bg_nxt     = '0;
        pad_nxt    = '0;
      end
    end
  end

  assign push = push_cmd.has_main | push_cmd.trunc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bsp_pkg::PH_HEADER;
      pos_r    <= '0;
      fa_r     <= '0;
      flags_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      ch_r     <= '0;
      bg_r     <= '0;
      pad_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      fa_r     <= fa_nxt;
      flags_r  <= flags_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      ch_r     <= ch_nxt;
      bg_r     <= bg_nxt;
      pad_r    <= pad_nxt;
    end
  end

endmodule

// ===== rtl/bsp_queue.sv =====
// Short command queue between the parser front end and the result back end.
module bsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bsp_pkg::cmd_t head_cmd
);

  localparam int PW = bsp_pkg::QPTR_W;

  bsp_pkg::cmd_t entry_r [bsp_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == (PW+1)'(bsp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (PW+1)'(1);
    else if (!do_push && do_pop) count_nxt = count_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/bsp_back.sv =====
// Back end: expands queued commands into results and holds the output register.
module bsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  bsp_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bsp_pkg::out_item_t out_data
);

  logic               step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  bsp_pkg::out_item_t out_r, out_nxt;
  bsp_pkg::out_item_t item;
  logic               load;

  assign load = head_valid & (~out_valid_r | ~out_stall);

  always_comb begin
    item          = '0;
    item.kind     = bsp_pkg::KIND_ERROR;
    item.error_code = bsp_pkg::ERR_TRUNC;
    item.last     = 1'b1;
    pop           = 1'b0;
    step_nxt      = step_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (!step_r && head_cmd.has_main) begin
      item      = head_cmd.res;
      item.last = ~head_cmd.trunc;
    end

    if (load) begin
      out_nxt       = item;
      out_valid_nxt = 1'b1;
      // Main result first; hold the entry when a truncation error still follows.
      if (!step_r && head_cmd.has_main && head_cmd.trunc) begin
        step_nxt = 1'b1;
      end else begin
        step_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/bmp_stream_parser_core.sv =====
// Top level of the BMP stream parser: front end, command queue, back end.
//
//   channel | ports                          | moves per transfer
//   --------+--------------------------------+-----------------------------------
//   input   | in_valid, in_stall, in_data    | one file byte and its end flag
//   output  | out_valid, out_stall, out_data | one pixel, header or error result
//
// One byte is taken per clock while in_stall is low; the front end classifies it
// in that cycle. Each byte yields zero, one or two results; the back end sends
// one per clock while out_stall is low, so a file-end byte that also gives a
// header or pixel result needs two sends. The four-entry queue absorbs that and
// output stalls; in_stall is high only while the queue is full. A byte's results
// pass through a queue entry and then the output register. rst_n is synchronous,
// active low, and clears parser state, queue pointers and the output valid flag.
module bmp_stream_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bsp_pkg::out_item_t out_data
);

  logic          q_full;
  logic          push;
  bsp_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  bsp_pkg::cmd_t head_cmd;

  bsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  bsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // A pending command with a free output stage must reach the output next cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !out_stall |=> out_valid)
    else $error("queued command not delivered");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push while queue full");

  // Every error ends the results of its byte.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == bsp_pkg::KIND_ERROR |-> out_data.last)
    else $error("error result not marked last");

endmodule
